FILE: rtl/fmsx_pkg.sv
// Shared types, codes and constants for the FM voice-bank unpacker.
// Used by every module of the block; depends on nothing.

package fmsx_pkg;

  // Message framing bytes and header values.
  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] SYX_END   = 8'hF7;
  localparam logic [7:0] MFR_ID    = 8'h43;
  localparam logic [6:0] FMT_VOICE = 7'd0;
  localparam logic [6:0] FMT_BANK  = 7'd9;

  // Payload sizes of the two formats.
  localparam logic [12:0] VOICE_BYTES = 13'd155;
  localparam logic [12:0] BANK_BYTES  = 13'd4096;

  // Header bytes after the start byte, and the header position of the format byte.
  localparam logic [2:0] HDR_LEN     = 3'd5;
  localparam logic [2:0] HDR_FMT_POS = 3'd2;

  // Result kinds.
  localparam logic [1:0] KIND_PARAM   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_NO_BANK = 2'd3;

  // Parser phases.
  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // Most results that one input byte can cause.
  localparam int MAX_RESULTS = 3;

  // Voice counts reported on acceptance.
  localparam logic [5:0] COUNT_VOICE = 6'd1;
  localparam logic [5:0] COUNT_BANK  = 6'd32;

  // Legal maxima of the 21 per-operator parameters.
  localparam logic [6:0] OP_LIMIT [21] = '{
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd3, 7'd3, 7'd7, 7'd3, 7'd7, 7'd99, 7'd1, 7'd31, 7'd99, 7'd14
  };

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] voice_index;
    logic [7:0] param_index;
    logic [6:0] param_value;
    logic [5:0] voice_count;
    logic [6:0] checksum;
  } result_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  header_position;
    logic [12:0] data_count;
    logic        is_bank_format;
    logic [6:0]  byte_sum;
    logic [3:0]  held_detune;
    logic        bank_found;
  } state_t;

  // One unpacked parameter before clamping.
  typedef struct packed {
    logic       vld;
    logic [7:0] idx;
    logic [6:0] raw;
  } pslot_t;

  // Legal maximum of a voice parameter.
  function automatic logic [6:0] limit_of(input logic [7:0] idx);
    logic [6:0] lim;
    logic [7:0] fld;
    lim = 7'd127;
    fld = 8'd0;
    if (idx < 8'd126) begin
      for (int k = 0; k < 6; k++) begin
        if (idx >= 8'(k * 21) && idx < 8'(k * 21 + 21)) begin
          fld = idx - 8'(k * 21);
        end
      end
      lim = OP_LIMIT[fld[4:0]];
    end else if (idx < 8'd134) begin
      lim = 7'd99;
    end else begin
      unique case (idx)
        8'd134:                         lim = 7'd31;
        8'd135:                         lim = 7'd7;
        8'd136:                         lim = 7'd1;
        8'd137, 8'd138, 8'd139, 8'd140: lim = 7'd99;
        8'd141:                         lim = 7'd1;
        8'd142, 8'd143:                 lim = 7'd7;
        8'd144:                         lim = 7'd48;
        default:                        lim = 7'd127;
      endcase
    end
    return lim;
  endfunction

endpackage

FILE: rtl/fmsx_if.sv
// Valid/ready channel interfaces for the input bytes and the result items.
// Depends on nothing.

interface fmsx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface fmsx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] voice_index;
  logic [7:0] param_index;
  logic [6:0] param_value;
  logic [5:0] voice_count;
  logic [6:0] checksum;
  logic       run_last;

  modport source (output valid, output kind, output voice_index, output param_index,
                  output param_value, output voice_count, output checksum,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input voice_index, input param_index,
                  input param_value, input voice_count, input checksum,
                  input run_last, output ready);
endinterface

FILE: rtl/fmsx_unpack.sv
// Maps one data byte at its payload position to up to three raw voice parameters.
// Depends on fmsx_pkg.

module fmsx_unpack (
  input  logic                 is_bank,
  input  logic [7:0]           data_pos,
  input  logic [7:0]           data_byte,
  input  logic [3:0]           held_detune,
  output fmsx_pkg::pslot_t [2:0] slot,
  output logic                 held_we,
  output logic [3:0]           held_val
);

  logic [6:0] off;
  logic [2:0] op;
  logic [4:0] j;
  logic [7:0] base;
  logic [7:0] b;

  assign b        = data_byte;
  assign off      = data_pos[6:0];
  assign held_val = b[6:3];

  // Operator number and byte within the 17-byte operator record.
  always_comb begin
    op = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (off >= 7'(k * 17)) begin
        op = 3'(k);
      end
    end
  end

  assign j    = 5'(off - 7'(op) * 7'd17);
  assign base = 8'(op) * 8'd21;

  // Field split of the packed layout.
  always_comb begin
    slot    = '0;
    held_we = 1'b0;
    if (!is_bank) begin
      slot[0] = '{vld: 1'b1, idx: data_pos, raw: b[6:0]};
    end else if (off < 7'd102) begin
      case (j)
        5'd11: begin
          slot[0] = '{vld: 1'b1, idx: base + 8'd11, raw: 7'(b[1:0])};
          slot[1] = '{vld: 1'b1, idx: base + 8'd12, raw: 7'(b[3:2])};
        end
        5'd12: begin
          held_we = 1'b1;
          slot[0] = '{vld: 1'b1, idx: base + 8'd13, raw: 7'(b[2:0])};
        end
        5'd13: begin
          slot[0] = '{vld: 1'b1, idx: base + 8'd14, raw: 7'(b[1:0])};
          slot[1] = '{vld: 1'b1, idx: base + 8'd15, raw: 7'(b[4:2])};
        end
        5'd14: begin
          slot[0] = '{vld: 1'b1, idx: base + 8'd16, raw: b[6:0]};
        end
        5'd15: begin
          slot[0] = '{vld: 1'b1, idx: base + 8'd17, raw: 7'(b[0])};
          slot[1] = '{vld: 1'b1, idx: base + 8'd18, raw: 7'(b[5:1])};
        end
        5'd16: begin
          // Fine frequency, then the detune held from the earlier byte.
          slot[0] = '{vld: 1'b1, idx: base + 8'd19, raw: b[6:0]};
          slot[1] = '{vld: 1'b1, idx: base + 8'd20, raw: 7'(held_detune)};
        end
        default: begin
          slot[0] = '{vld: 1'b1, idx: base + 8'(j), raw: b[6:0]};
        end
      endcase
    end else if (off < 7'd110) begin
      slot[0] = '{vld: 1'b1, idx: 8'(off) + 8'd24, raw: b[6:0]};
    end else if (off == 7'd110) begin
      slot[0] = '{vld: 1'b1, idx: 8'd134, raw: 7'(b[4:0])};
    end else if (off == 7'd111) begin
      slot[0] = '{vld: 1'b1, idx: 8'd135, raw: 7'(b[2:0])};
      slot[1] = '{vld: 1'b1, idx: 8'd136, raw: 7'(b[3])};
    end else if (off < 7'd116) begin
      slot[0] = '{vld: 1'b1, idx: 8'(off) + 8'd25, raw: b[6:0]};
    end else if (off == 7'd116) begin
      slot[0] = '{vld: 1'b1, idx: 8'd141, raw: 7'(b[0])};
      slot[1] = '{vld: 1'b1, idx: 8'd142, raw: 7'(b[3:1])};
      slot[2] = '{vld: 1'b1, idx: 8'd143, raw: 7'(b[6:4])};
    end else if (off == 7'd117) begin
      slot[0] = '{vld: 1'b1, idx: 8'd144, raw: b[6:0]};
    end else begin
      slot[0] = '{vld: 1'b1, idx: 8'(off) + 8'd27, raw: b[6:0]};
    end
  end

endmodule

FILE: rtl/fmsx_step.sv
// Next-state and result logic of the parser for one input byte.
// Depends on fmsx_pkg and fmsx_unpack.

module fmsx_step (
  input  fmsx_pkg::state_t         st,
  input  logic [7:0]               data_byte,
  input  logic                     end_of_file,
  output fmsx_pkg::state_t         st_nxt,
  output fmsx_pkg::result_t [2:0]  res,
  output logic [1:0]               res_count
);

  fmsx_pkg::pslot_t [2:0] slot;
  logic                   held_we;
  logic [3:0]             held_val;
  logic                   below_need;
  logic                   at_most_need;
  logic                   full_msg;
  logic [6:0]             csum;
  logic [6:0]             fmt;
  logic [2:0]             hdr_inc;
  fmsx_pkg::result_t      pres;

  fmsx_unpack u_unpack (
    .is_bank     (st.is_bank_format),
    .data_pos    (st.data_count[7:0]),
    .data_byte   (data_byte),
    .held_detune (st.held_detune),
    .slot        (slot),
    .held_we     (held_we),
    .held_val    (held_val)
  );

  // Length checks against the payload size of the current format.
  always_comb begin
    if (st.is_bank_format) begin
      below_need   = st.data_count < fmsx_pkg::BANK_BYTES;
      at_most_need = st.data_count <= fmsx_pkg::BANK_BYTES;
    end else begin
      below_need   = st.data_count < fmsx_pkg::VOICE_BYTES;
      at_most_need = st.data_count <= fmsx_pkg::VOICE_BYTES;
    end
  end

  assign full_msg = !at_most_need;
  assign csum     = 7'd0 - st.byte_sum;
  assign fmt      = data_byte[6:0];
  assign hdr_inc  = st.header_position + 3'd1;

  // Parser transition and result list.
  always_comb begin
    st_nxt    = st;
    res       = '0;
    res_count = 2'd0;
    pres      = '0;
    unique case (st.phase)
      fmsx_pkg::PH_HUNT: begin
        if (data_byte == fmsx_pkg::SYX_START) begin
          st_nxt.phase           = fmsx_pkg::PH_HEADER;
          st_nxt.header_position = 3'd0;
        end
      end
      fmsx_pkg::PH_HEADER: begin
        if (data_byte == fmsx_pkg::SYX_END) begin
          st_nxt.phase = fmsx_pkg::PH_HUNT;
        end else if (st.header_position == 3'd0 && data_byte != fmsx_pkg::MFR_ID) begin
          st_nxt.phase = fmsx_pkg::PH_SKIP;
        end else if (st.header_position == fmsx_pkg::HDR_FMT_POS &&
                     fmt != fmsx_pkg::FMT_VOICE && fmt != fmsx_pkg::FMT_BANK) begin
          st_nxt.phase = fmsx_pkg::PH_SKIP;
        end else begin
          if (st.header_position == fmsx_pkg::HDR_FMT_POS) begin
            st_nxt.is_bank_format = (fmt == fmsx_pkg::FMT_BANK);
          end
          st_nxt.header_position = hdr_inc;
          if (hdr_inc >= fmsx_pkg::HDR_LEN) begin
            st_nxt.phase           = fmsx_pkg::PH_DATA;
            st_nxt.header_position = 3'd0;
            st_nxt.data_count      = 13'd0;
            st_nxt.byte_sum        = 7'd0;
            st_nxt.held_detune     = 4'd0;
          end
        end
      end
      fmsx_pkg::PH_DATA: begin
        if (data_byte == fmsx_pkg::SYX_END) begin
          if (full_msg) begin
            res[0].kind        = fmsx_pkg::KIND_ACCEPT;
            res[0].voice_count = st.is_bank_format ? fmsx_pkg::COUNT_BANK
                                                   : fmsx_pkg::COUNT_VOICE;
            res[0].checksum    = csum;
            st_nxt.bank_found  = 1'b1;
            st_nxt.phase       = fmsx_pkg::PH_DONE;
          end else begin
            res[0].kind     = fmsx_pkg::KIND_REJECT;
            res[0].checksum = csum;
            st_nxt.phase    = fmsx_pkg::PH_HUNT;
          end
          res_count = 2'd1;
        end else begin
          if (below_need) begin
            st_nxt.byte_sum = st.byte_sum + data_byte[6:0];
            if (!end_of_file) begin
              if (held_we) begin
                st_nxt.held_detune = held_val;
              end
              // Slots are filled from the bottom, so the count indexes the next free entry.
              for (int k = 0; k < fmsx_pkg::MAX_RESULTS; k++) begin
                if (slot[k].vld) begin
                  pres.kind        = fmsx_pkg::KIND_PARAM;
                  pres.voice_index = st.is_bank_format ? st.data_count[11:7] : 5'd0;
                  pres.param_index = slot[k].idx;
                  pres.param_value = (slot[k].raw > fmsx_pkg::limit_of(slot[k].idx)) ?
                                     fmsx_pkg::limit_of(slot[k].idx) : slot[k].raw;
                  pres.voice_count = 6'd0;
                  pres.checksum    = 7'd0;
                  res[res_count]   = pres;
                  res_count        = res_count + 2'd1;
                end
              end
            end
          end
          if (at_most_need) begin
            st_nxt.data_count = st.data_count + 13'd1;
          end
        end
      end
      fmsx_pkg::PH_SKIP: begin
        if (data_byte == fmsx_pkg::SYX_END) begin
          st_nxt.phase = fmsx_pkg::PH_HUNT;
        end
      end
      default: begin
      end
    endcase

    // End of file: report a file without a bank, then start over.
    if (end_of_file) begin
      if (!st_nxt.bank_found) begin
        pres           = '0;
        pres.kind      = fmsx_pkg::KIND_NO_BANK;
        res[res_count] = pres;
        res_count      = res_count + 2'd1;
      end
      st_nxt       = '0;
      st_nxt.phase = fmsx_pkg::PH_HUNT;
    end
  end

endmodule

FILE: rtl/fmsx_obuf.sv
// Result register: holds one byte's results, handed out one per cycle while out_chan is ready.
// Depends on fmsx_pkg and the fmsx_out_if interface.

module fmsx_obuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  fmsx_pkg::result_t [2:0] res,
  input  logic [1:0]              res_count,
  output logic                    can_load,
  fmsx_out_if.source              out_chan
);

  fmsx_pkg::result_t [2:0] slot_r;
  logic [1:0]              remain_r;
  logic                    pop;

  assign pop      = out_chan.valid && out_chan.ready;
  assign can_load = (remain_r == 2'd0) || (remain_r == 2'd1 && out_chan.ready);

  // Count of results still to deliver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= 2'd0;
    end else if (load) begin
      remain_r <= res_count;
    end else if (pop) begin
      remain_r <= remain_r - 2'd1;
    end
  end

  // Result slots; the head moves down as results leave.
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= res;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  // Drive the result channel from the head slot.
  assign out_chan.valid       = remain_r != 2'd0;
  assign out_chan.kind        = slot_r[0].kind;
  assign out_chan.voice_index = slot_r[0].voice_index;
  assign out_chan.param_index = slot_r[0].param_index;
  assign out_chan.param_value = slot_r[0].param_value;
  assign out_chan.voice_count = slot_r[0].voice_count;
  assign out_chan.checksum    = slot_r[0].checksum;
  assign out_chan.run_last    = remain_r == 2'd1;

endmodule

FILE: rtl/fm_sysex_voice_unpacker_unit.sv
// Top level of the FM voice-bank unpacker: parser state, step logic, result register.
// Depends on fmsx_pkg, fmsx_if, fmsx_step and fmsx_obuf.
//
//   channel   | role   | request carries
//   ----------+--------+--------------------------------------------------------
//   in_chan   | sink   | data_byte, end_of_file
//   out_chan  | source | kind, voice_index, param_index, param_value,
//             |        | voice_count, checksum, run_last
//
// A byte is decoded in the cycle it is taken, and its results appear from the
// result register in the next cycle, one per cycle while the result channel is
// ready. A byte that yields zero or one result leaves the input ready every
// cycle; one that yields two or three holds the input while the result register
// drains. Reset is synchronous and active low; it clears the parser state and
// empties the result register. A stalled result channel stalls the input as
// soon as the result register holds any result.

module fm_sysex_voice_unpacker_unit (
  input  logic       clk,
  input  logic       rst_n,
  fmsx_in_if.sink    in_chan,
  fmsx_out_if.source out_chan
);

  fmsx_pkg::state_t        state_r;
  fmsx_pkg::state_t        state_nxt;
  fmsx_pkg::result_t [2:0] res;
  logic [1:0]              res_count;
  logic                    can_load;
  logic                    accept;

  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid && can_load;

  fmsx_step u_step (
    .st          (state_r),
    .data_byte   (in_chan.data_byte),
    .end_of_file (in_chan.end_of_file),
    .st_nxt      (state_nxt),
    .res         (res),
    .res_count   (res_count)
  );

  // Parser state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: fmsx_pkg::PH_HUNT, default: '0};
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  fmsx_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .res_count (res_count),
    .can_load  (can_load),
    .out_chan  (out_chan)
  );

endmodule
